[hw/rtl/directory_record_parser_defines.svh]
// Assertion macros shared by the directory record parser RTL.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef DIRECTORY_RECORD_PARSER_DEFINES_SVH
`define DIRECTORY_RECORD_PARSER_DEFINES_SVH

// Checked only outside reset.
`define DRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define DRP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/drp_pkg.sv]
// Types and constants for the directory record parser.
// No dependencies; used by drp_core, drp_fifo and directory_record_parser.
package drp_pkg;

  localparam int unsigned POS_W            = 17;
  localparam int unsigned BLOCK_BYTES_DFLT = 4096;
  localparam int unsigned QUEUE_DEPTH_DFLT = 4;
  localparam int unsigned HDR_BYTES        = 8;
  localparam int unsigned REC_ALIGN        = 4;
  localparam int unsigned NAME_LIMIT       = 255;
  localparam int unsigned TYPE_LIMIT       = 7;
  localparam int unsigned CFG_INDEX_W      = 1;
  localparam int unsigned CFG_DATA_W       = 32;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TYPE_BYTE   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INODE_COUNT = 1'd1;

  // result kinds
  localparam logic [1:0] KIND_ENTRY  = 2'd0;
  localparam logic [1:0] KIND_NAME   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_HDR_CROSS = 3'd1,
    ERR_SHORT     = 3'd2,
    ERR_ALIGN     = 3'd3,
    ERR_OVERRUN   = 3'd4,
    ERR_NAME      = 3'd5,
    ERR_TYPE      = 3'd6,
    ERR_INODE     = 3'd7
  } err_code_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             block_first;
    logic             block_last;
    logic [POS_W-1:0] block_limit;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] entry_inode;
    logic [15:0] record_length;
    logic [15:0] name_length;
    logic [7:0]  entry_type;
    logic [15:0] record_offset;
    logic [2:0]  error_code;
    logic        stops_block;
    logic [7:0]  name_byte;
    logic        name_last;
    logic        block_bad;
  } out_word_t;

  // results produced by one accepted byte, in order
  typedef struct packed {
    logic [1:0] count;
    out_word_t  word0;
    out_word_t  word1;
  } push_t;

endpackage

[hw/rtl/drp_fifo.sv]
// Result queue: takes up to two words per cycle, hands out one while out_ready is high.
// Depends on drp_pkg and directory_record_parser_defines.svh.
`include "directory_record_parser_defines.svh"

module drp_fifo #(
  parameter int unsigned DEPTH = drp_pkg::QUEUE_DEPTH_DFLT
) (
  input  logic              clk,
  input  logic              rst,
  input  drp_pkg::push_t    push,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output drp_pkg::out_word_t out_word
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  drp_pkg::out_word_t mem [DEPTH];
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   wr_ptr1;
  logic [PTR_W-1:0]   wr_ptr_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_word  = mem[rd_ptr];
  assign space     = (count <= CNT_W'(DEPTH - 2));
  assign wr_ptr1   = ptr_inc(wr_ptr);

  always_comb begin
    count_next = count + CNT_W'(push.count) - CNT_W'(pop);
    unique case (push.count)
      2'd1:    wr_ptr_next = wr_ptr1;
      2'd2:    wr_ptr_next = ptr_inc(wr_ptr1);
      default: wr_ptr_next = wr_ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.word0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr1] <= push.word1;
    end
  end

  `DRP_ASSERT(a_count_bound, count <= CNT_W'(DEPTH), "result queue count above depth")
  `DRP_ASSERT(a_push_room, push.count != 2'd0 |-> count <= CNT_W'(DEPTH - 2), "push while full")
  `DRP_ASSERT(a_pop_only, pop && push.count == 2'd0 |=> count == $past(count) - 1'b1, "pop lost")

endmodule

[hw/rtl/drp_core.sv]
// Per-byte record parser: header capture, checks, name stream, block status.
// Depends on drp_pkg and directory_record_parser_defines.svh.
`include "directory_record_parser_defines.svh"

module drp_core #(
  parameter int unsigned BLOCK_BYTES = drp_pkg::BLOCK_BYTES_DFLT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [drp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [drp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             accept,
  input  drp_pkg::in_word_t                in_word,
  output drp_pkg::push_t                   push
);

  localparam int unsigned POS_W = drp_pkg::POS_W;
  localparam int unsigned SUM_W = POS_W + 1;
  localparam logic [POS_W-1:0] LIM_MAX = POS_W'(BLOCK_BYTES);

  typedef enum logic [1:0] {PH_HEADER, PH_NAME, PH_SKIP, PH_STOPPED} phase_t;

  // state
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] rec_start;
  logic [7:0][7:0]  hdr;
  phase_t           phase;
  logic [15:0]      names_left;
  logic             any_corrupt;
  logic             type_en;
  logic [31:0]      inode_count;

  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] rec_start_next;
  logic [7:0][7:0]  hdr_next;
  phase_t           phase_next;
  logic [15:0]      names_left_next;
  logic             any_corrupt_next;

  // state as seen after a block restart
  logic [POS_W-1:0] pos_b;
  logic [POS_W-1:0] rec_start_b;
  logic [7:0][7:0]  hdr_b;
  phase_t           phase_b;
  logic [15:0]      names_left_b;
  logic             any_corrupt_b;

  logic [POS_W-1:0] lim;
  logic [POS_W-1:0] rel;
  logic [POS_W-1:0] remaining;
  logic [7:0][7:0]  hdr7;
  logic [31:0]      ino;
  logic [15:0]      rl7;
  logic [15:0]      nl7;
  logic [7:0]       ty7;
  drp_pkg::err_code_t err7;
  logic             fatal7;
  logic             report7;
  logic [15:0]      rec_cur;
  logic [15:0]      left_dec;
  drp_pkg::out_word_t word_a;
  drp_pkg::out_word_t word_s;
  logic             have_a;
  logic             have_s;

  // header field decode, valid when rel is 7
  always_comb begin
    hdr7    = hdr_b;
    hdr7[7] = in_word.data_byte;
    ino     = hdr7[3:0];
    rl7     = hdr7[5:4];
    nl7     = type_en ? {8'h00, hdr7[6]} : hdr7[7:6];
    ty7     = type_en ? hdr7[7] : 8'h00;
    fatal7  = 1'b1;
    if (rl7 < 16'(drp_pkg::HDR_BYTES)) begin
      err7 = drp_pkg::ERR_SHORT;
    end else if (rl7[1:0] != 2'b00) begin
      err7 = drp_pkg::ERR_ALIGN;
    end else if (POS_W'(rl7) > remaining) begin
      err7 = drp_pkg::ERR_OVERRUN;
    end else begin
      fatal7 = 1'b0;
      if (nl7 > 16'(drp_pkg::NAME_LIMIT) || nl7 > rl7 - 16'(drp_pkg::HDR_BYTES)) begin
        err7 = drp_pkg::ERR_NAME;
      end else if (ino > inode_count) begin
        err7 = drp_pkg::ERR_INODE;
      end else if (type_en && ty7 > 8'(drp_pkg::TYPE_LIMIT)) begin
        err7 = drp_pkg::ERR_TYPE;
      end else begin
        err7 = drp_pkg::ERR_NONE;
      end
    end
    report7 = (ino != 32'd0) || (err7 != drp_pkg::ERR_NONE);
  end

  always_comb begin
    lim = (in_word.block_limit > LIM_MAX) ? LIM_MAX : in_word.block_limit;

    if (in_word.block_first) begin
      pos_b         = '0;
      rec_start_b   = '0;
      hdr_b         = '0;
      phase_b       = PH_HEADER;
      names_left_b  = '0;
      any_corrupt_b = 1'b0;
    end else begin
      pos_b         = pos;
      rec_start_b   = rec_start;
      hdr_b         = hdr;
      phase_b       = phase;
      names_left_b  = names_left;
      any_corrupt_b = any_corrupt;
    end

    pos_next         = pos_b;
    rec_start_next   = rec_start_b;
    hdr_next         = hdr_b;
    phase_next       = phase_b;
    names_left_next  = names_left_b;
    any_corrupt_next = any_corrupt_b;

    rel       = pos_b - rec_start_b;
    remaining = (lim > rec_start_b) ? lim - rec_start_b : '0;
    rec_cur   = (phase_b == PH_HEADER) ? rl7 : hdr_b[5:4];
    left_dec  = names_left_b - 16'd1;

    word_a = '0;
    word_s = '0;
    have_a = 1'b0;
    have_s = 1'b0;

    if (pos_b < lim && phase_b != PH_STOPPED) begin
      if (phase_b == PH_HEADER) begin
        if (rel == '0 && remaining < POS_W'(drp_pkg::HDR_BYTES)) begin
          // too few bytes left for a header
          have_a               = 1'b1;
          word_a.result_kind   = drp_pkg::KIND_ENTRY;
          word_a.record_offset = rec_start_b[15:0];
          word_a.error_code    = drp_pkg::ERR_HDR_CROSS;
          word_a.stops_block   = 1'b1;
          any_corrupt_next     = 1'b1;
          phase_next           = PH_STOPPED;
          hdr_next             = '0;
        end else if (rel < POS_W'(drp_pkg::HDR_BYTES)) begin
          if (rel == '0) begin
            hdr_next = '0;
          end
          hdr_next[rel[2:0]] = in_word.data_byte;
          if (rel[2:0] == 3'd7) begin
            if (report7) begin
              have_a               = 1'b1;
              word_a.result_kind   = drp_pkg::KIND_ENTRY;
              word_a.entry_inode   = ino;
              word_a.record_length = rl7;
              word_a.name_length   = nl7;
              word_a.entry_type    = ty7;
              word_a.record_offset = rec_start_b[15:0];
              word_a.error_code    = err7;
              word_a.stops_block   = fatal7;
            end
            if (err7 != drp_pkg::ERR_NONE) begin
              any_corrupt_next = 1'b1;
            end
            if (fatal7) begin
              phase_next = PH_STOPPED;
            end else begin
              names_left_next = (report7 && err7 != drp_pkg::ERR_NAME) ? nl7 : 16'd0;
              phase_next      = (names_left_next != 16'd0) ? PH_NAME : PH_SKIP;
            end
          end
        end
      end else if (phase_b == PH_NAME) begin
        have_a               = 1'b1;
        word_a.result_kind   = drp_pkg::KIND_NAME;
        word_a.record_offset = rec_start_b[15:0];
        word_a.name_byte     = in_word.data_byte;
        word_a.name_last     = (left_dec == 16'd0);
        names_left_next      = left_dec;
        if (left_dec == 16'd0) begin
          phase_next = PH_SKIP;
        end
      end

      // end of record: next byte starts a header
      if ((phase_next == PH_NAME || phase_next == PH_SKIP) &&
          ({1'b0, pos_b} + SUM_W'(1)) >= ({1'b0, rec_start_b} + SUM_W'(rec_cur))) begin
        rec_start_next  = pos_b + 1'b1;
        names_left_next = '0;
        phase_next      = PH_HEADER;
      end
    end

    pos_next = (pos_b == '1) ? pos_b : pos_b + 1'b1;

    if (in_word.block_last) begin
      have_s             = 1'b1;
      word_s.result_kind = drp_pkg::KIND_STATUS;
      word_s.block_bad   = any_corrupt_next;
      phase_next         = PH_STOPPED;
    end

    push.count = accept ? {have_a && have_s, have_a ^ have_s} : 2'd0;
    push.word0 = have_a ? word_a : word_s;
    push.word1 = word_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      rec_start   <= '0;
      hdr         <= '0;
      phase       <= PH_HEADER;
      names_left  <= '0;
      any_corrupt <= 1'b0;
      type_en     <= 1'b1;
      inode_count <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          drp_pkg::REG_TYPE_BYTE:   type_en     <= cfg_data[0];
          drp_pkg::REG_INODE_COUNT: inode_count <= cfg_data[31:0];
          default:                  type_en     <= type_en;
        endcase
      end
      if (accept) begin
        pos         <= pos_next;
        rec_start   <= rec_start_next;
        hdr         <= hdr_next;
        phase       <= phase_next;
        names_left  <= names_left_next;
        any_corrupt <= any_corrupt_next;
      end
    end
  end

  `DRP_ASSERT(a_last_stops, accept && in_word.block_last |=> phase == PH_STOPPED, "not stopped")
  `DRP_ASSERT(a_name_left, (phase == PH_NAME) |-> (names_left != 16'd0), "empty name phase")
  `DRP_ASSERT_ALWAYS(a_idle_push, !accept |-> push.count == 2'd0, "push while idle")

endmodule

[hw/rtl/directory_record_parser.sv]
// Top level of the directory record parser: parse core plus result queue.
// Depends on drp_pkg, drp_core and drp_fifo.
//
//   channel | direction | handshake               | payload
//   cfg     | in        | cfg_write               | cfg_index, cfg_data
//   in      | in        | in_valid / in_ready     | in_word  (drp_pkg::in_word_t)
//   out     | out       | out_valid / out_ready   | out_word (drp_pkg::out_word_t)
//
// One input byte is taken per cycle while in_ready is high; its header, name or
// status words are formed in the same cycle and written into a QUEUE_DEPTH-word
// result queue. A byte that yields two words (a header or name byte plus the
// block status) hands them out one at a time through the single output port.
// in_ready is high while the queue has room for two words, so back-pressure
// on out_ready reaches the input once fewer than two entries are free.
// Reset is synchronous and clears parse state and the queue; there is no
// clearing pass.
module directory_record_parser #(
  parameter int unsigned BLOCK_BYTES = drp_pkg::BLOCK_BYTES_DFLT,
  parameter int unsigned QUEUE_DEPTH = drp_pkg::QUEUE_DEPTH_DFLT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [drp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [drp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  drp_pkg::in_word_t               in_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output drp_pkg::out_word_t              out_word
);

  drp_pkg::push_t push;
  logic           accept;

  assign accept = in_valid && in_ready;

  drp_core #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_word   (in_word),
    .push      (push)
  );

  drp_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
